// ===== rtl/core/pta_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the period tachometer with running average.
// No dependencies; used by the result channel interface and the top level.
package pta_pkg;

    // Field and register widths
    localparam int unsigned DATA_W = 32;
    localparam int unsigned IDX_W  = 2;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] CFG_TICKS_PER_MINUTE = 2'd0;
    localparam logic [IDX_W-1:0] CFG_TIMEOUT_TICKS    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_REPORT_TICKS     = 2'd2;

    // Reset values of the registers
    localparam logic [DATA_W-1:0] TPM_RST     = 32'd60000000;
    localparam logic [DATA_W-1:0] TIMEOUT_RST = 32'd5000000;
    localparam logic [DATA_W-1:0] REPORT_RST  = 32'd1000000;

    // Saturation value of the tick counters
    localparam logic [DATA_W-1:0] CNT_MAX = '1;

    // Serial divider: dividend holds avg*5 + speed, so three extra bits
    localparam int unsigned QUO_W   = DATA_W + 3;
    localparam int unsigned STEP_W  = $clog2(QUO_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

    // Weights of the running average
    localparam logic [DATA_W-1:0] AVG_DIVISOR = 32'd6;

endpackage

// ===== rtl/core/pta_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: one sensor level sample per request.
// Depends on pta_pkg for nothing but is kept next to it.
interface pta_in_if;
    logic valid;
    logic ready;
    logic sensor_level;

    modport source (output valid, output sensor_level, input ready);
    modport sink   (input valid, input sensor_level, output ready);
endinterface

// ===== rtl/core/pta_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: speed, average and strobes for one tick.
// Depends on pta_pkg for the field widths.
interface pta_out_if;
    logic                         valid;
    logic                         ready;
    logic [pta_pkg::DATA_W-1:0]   speed_rpm;
    logic [pta_pkg::DATA_W-1:0]   average_rpm;
    logic                         new_value;
    logic                         report;

    modport source (output valid, output speed_rpm, output average_rpm,
                    output new_value, output report, input ready);
    modport sink   (input valid, input speed_rpm, input average_rpm,
                    input new_value, input report, output ready);
endinterface

// ===== rtl/core/period_tachometer_with_average_unit.sv =====
`timescale 1ns / 1ps
// Period tachometer with running average, single-module core.
// Depends on pta_pkg, pta_in_if and pta_out_if.
//
// Each request carries one sensor sample per microsecond tick and yields
// exactly one result. A tick with no falling edge, or one that lands in
// timeout, is updated and then written to the result register. A falling
// edge that is not timed out runs a restoring divider one quotient bit
// per cycle, twice: rpm = ticks_per_minute / period, then
// average = (average*5 + rpm) / 6, each 35 steps. Both divisions share
// one serial divider. A new request is taken once the previous tick's
// result sits in the output register, even if the sink has not yet
// taken it. Tick counters saturate at 2^32-1.
module period_tachometer_with_average_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pta_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [pta_pkg::DATA_W-1:0]   i_cfg_data,
    pta_in_if.sink                       i_in,
    pta_out_if.source                    o_out
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DIV_SPD = 3'd1;
    localparam logic [2:0] ST_AVG_LD  = 3'd2;
    localparam logic [2:0] ST_DIV_AVG = 3'd3;
    localparam logic [2:0] ST_AVG_WR  = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    // Configuration and tracking state
    logic [pta_pkg::DATA_W-1:0] r_tpm, r_timeout, r_rep_ticks;
    logic                       r_prev;
    logic [pta_pkg::DATA_W-1:0] r_tse, r_rc, r_speed, r_avg;
    logic                       r_fresh, r_strobe;
    logic [2:0]                 r_state;

    // Serial divider
    logic [pta_pkg::QUO_W-1:0]  r_quo;
    logic [pta_pkg::DATA_W-1:0] r_rem, r_div;
    logic [pta_pkg::STEP_W-1:0] r_step;

    // Output register
    logic                       r_ov;
    logic [pta_pkg::DATA_W-1:0] r_o_speed, r_o_avg;
    logic                       r_o_new, r_o_rep;

    // Next values
    logic [pta_pkg::DATA_W-1:0] n_tse, n_rc, n_speed, n_avg, n_rem, n_div;
    logic [pta_pkg::DATA_W-1:0] n_o_speed, n_o_avg;
    logic                       n_prev, n_fresh, n_strobe, n_ov, n_o_new, n_o_rep;
    logic [2:0]                 n_state;
    logic [pta_pkg::QUO_W-1:0]  n_quo;
    logic [pta_pkg::STEP_W-1:0] n_step;

    // Per-tick combinational terms
    logic                       accept, fall, timed_out, strobe, out_free;
    logic [pta_pkg::DATA_W-1:0] elapsed, tse_upd, rc_inc, rc_upd;
    logic [pta_pkg::DATA_W:0]   trial, diff;
    logic                       ge;
    logic [pta_pkg::QUO_W-1:0]  avg_sum;

    assign i_in.ready   = (r_state == ST_IDLE);
    assign accept       = i_in.valid && (r_state == ST_IDLE);
    assign out_free     = !r_ov || o_out.ready;

    assign o_out.valid       = r_ov;
    assign o_out.speed_rpm   = r_o_speed;
    assign o_out.average_rpm = r_o_avg;
    assign o_out.new_value   = r_o_new;
    assign o_out.report      = r_o_rep;

    // Edge detect, period count and report phase
    always_comb begin
        fall      = r_prev && !i_in.sensor_level;
        elapsed   = (r_tse == pta_pkg::CNT_MAX) ? r_tse : r_tse + 1'b1;
        tse_upd   = fall ? '0 : elapsed;
        timed_out = (tse_upd >= r_timeout);
        rc_inc    = (r_rc == pta_pkg::CNT_MAX) ? r_rc : r_rc + 1'b1;
        strobe    = (rc_inc >= r_rep_ticks);
        rc_upd    = strobe ? rc_inc - r_rep_ticks : rc_inc;
    end

    // One restoring step: shift in the next dividend bit, try the subtract
    always_comb begin
        trial = {r_rem, r_quo[pta_pkg::QUO_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
    end

    // Dividend of the average: avg*5 + speed
    assign avg_sum = {1'b0, r_avg, 2'b00} + {3'b000, r_avg}
                   + {3'b000, r_quo[pta_pkg::DATA_W-1:0]};

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_prev    = r_prev;
        n_tse     = r_tse;
        n_rc      = r_rc;
        n_speed   = r_speed;
        n_avg     = r_avg;
        n_fresh   = r_fresh;
        n_strobe  = r_strobe;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_div     = r_div;
        n_step    = r_step;
        n_ov      = r_ov && !o_out.ready;
        n_o_speed = r_o_speed;
        n_o_avg   = r_o_avg;
        n_o_new   = r_o_new;
        n_o_rep   = r_o_rep;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_prev   = i_in.sensor_level;
                    n_tse    = tse_upd;
                    n_rc     = rc_upd;
                    n_strobe = strobe;
                    n_fresh  = 1'b0;
                    n_state  = ST_DONE;
                    if (timed_out) begin
                        n_speed = '0;
                        n_avg   = '0;
                    end else if (fall) begin
                        n_quo   = {3'b000, r_tpm};
                        n_rem   = '0;
                        n_div   = elapsed;
                        n_step  = '0;
                        n_state = ST_DIV_SPD;
                    end
                end
            end
            ST_DIV_SPD, ST_DIV_AVG: begin
                n_rem  = ge ? diff[pta_pkg::DATA_W-1:0] : trial[pta_pkg::DATA_W-1:0];
                n_quo  = {r_quo[pta_pkg::QUO_W-2:0], ge};
                n_step = r_step + 1'b1;
                if (r_step == pta_pkg::LAST_STEP) begin
                    n_state = (r_state == ST_DIV_SPD) ? ST_AVG_LD : ST_AVG_WR;
                end
            end
            ST_AVG_LD: begin
                n_speed = r_quo[pta_pkg::DATA_W-1:0];
                n_quo   = avg_sum;
                n_rem   = '0;
                n_div   = pta_pkg::AVG_DIVISOR;
                n_step  = '0;
                n_state = ST_DIV_AVG;
            end
            ST_AVG_WR: begin
                n_avg   = r_quo[pta_pkg::DATA_W-1:0];
                n_fresh = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_o_speed = r_speed;
                    n_o_avg   = r_avg;
                    n_o_new   = r_fresh;
                    n_o_rep   = r_strobe;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ov        <= 1'b0;
            r_prev      <= 1'b0;
            r_tse       <= '0;
            r_rc        <= '0;
            r_speed     <= '0;
            r_avg       <= '0;
            r_tpm       <= pta_pkg::TPM_RST;
            r_timeout   <= pta_pkg::TIMEOUT_RST;
            r_rep_ticks <= pta_pkg::REPORT_RST;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_prev  <= n_prev;
            r_tse   <= n_tse;
            r_rc    <= n_rc;
            r_speed <= n_speed;
            r_avg   <= n_avg;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pta_pkg::CFG_TICKS_PER_MINUTE: r_tpm       <= i_cfg_data;
                    pta_pkg::CFG_TIMEOUT_TICKS:    r_timeout   <= i_cfg_data;
                    pta_pkg::CFG_REPORT_TICKS:     r_rep_ticks <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_fresh   <= n_fresh;
        r_strobe  <= n_strobe;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_div     <= n_div;
        r_step    <= n_step;
        r_o_speed <= n_o_speed;
        r_o_avg   <= n_o_avg;
        r_o_new   <= n_o_new;
        r_o_rep   <= n_o_rep;
    end

endmodule
